@@ rtl/core/hdm_pkg.sv @@
// ----------------------------------------------------------------------------
// hdm_pkg - shared types and constants for the holonomic drive mixer
// Widths of the offset, wheel and divider datapaths, plus the struct that
// carries the four wheel lanes through the rescale divider.
// ----------------------------------------------------------------------------
package hdm_pkg;

	localparam int AXIS_W   = 8;             // offset-127 byte
	localparam int OFF_W    = 9;             // axis offset, -127..128
	localparam int WHL_W    = 10;            // wheel offset, -383..384
	localparam int MAG_W    = 9;             // wheel magnitude, 0..384
	localparam int NUM_W    = 16;            // |wheel| * 127, up to 48768
	localparam int QUO_W    = 7;             // rescaled magnitude, 0..127
	localparam int DIV_STEPS = QUO_W;        // one quotient bit per stage
	localparam int N_AXES   = 3;
	localparam int N_WHEELS = 4;
	localparam int N_STAGES = 3 + DIV_STEPS; // shape, mix, limit, divider

	localparam int CENTRE   = 127;           // stop / centre value

	typedef logic [AXIS_W-1:0]        axis_t;
	typedef logic signed [OFF_W-1:0]  off_t;
	typedef logic signed [WHL_W-1:0]  whl_t;
	typedef logic [MAG_W-1:0]         mag_t;

	// Lane state through the restoring divider
	typedef struct packed {
		logic [N_WHEELS-1:0][NUM_W-1:0] rem;   // running remainder
		logic [N_WHEELS-1:0][QUO_W-1:0] quo;   // quotient bits so far
		logic [N_WHEELS-1:0]            neg;   // wheel offset negative
		logic [N_WHEELS-1:0][WHL_W-1:0] off;   // raw offset, pass-through
		logic [NUM_W-1:0]               dsr;   // limit aligned to top bit
		logic                           scale; // limit at or above 127
	} div_t;

endpackage

@@ rtl/core/hdm_intf.sv @@
// ----------------------------------------------------------------------------
// hdm_intf - stream channels of the holonomic drive mixer
// Valid/ready channels for the joystick sample and the wheel command set.
// ----------------------------------------------------------------------------
interface hdm_in_if import hdm_pkg::*; ();

	logic  valid;
	logic  ready;
	axis_t forward_axis;
	axis_t side_axis;
	axis_t rotate_axis;

	modport source (output valid, output forward_axis, output side_axis,
		output rotate_axis, input ready);
	modport sink (input valid, input forward_axis, input side_axis,
		input rotate_axis, output ready);

endinterface

interface hdm_out_if import hdm_pkg::*; ();

	logic  valid;
	logic  ready;
	axis_t front_left_pwm;
	axis_t front_right_pwm;
	axis_t back_left_pwm;
	axis_t back_right_pwm;

	modport source (output valid, output front_left_pwm, output front_right_pwm,
		output back_left_pwm, output back_right_pwm, input ready);
	modport sink (input valid, input front_left_pwm, input front_right_pwm,
		input back_left_pwm, input back_right_pwm, output ready);

endinterface

@@ rtl/core/holonomic_drive_mixer_top.sv @@
// ----------------------------------------------------------------------------
// holonomic_drive_mixer_top - four-wheel holonomic drive mixer
// Throughput: one joystick sample per cycle while wheels.ready does not stall
// the pipe; ten register stages (shape, mix, limit, seven one-bit divider
// steps) each hold one item.
// Reset: clears every stage valid bit and square_q to 0.
// ----------------------------------------------------------------------------
module holonomic_drive_mixer_top import hdm_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_we,
	input  logic      cfg_wdata,
	hdm_in_if.sink    axes,
	hdm_out_if.source wheels
);

	logic                square_q;
	logic [N_STAGES-1:0] vld_q;
	logic [N_STAGES-1:0] adv;

	off_t off_s1 [N_AXES];
	whl_t e_s2   [N_WHEELS];
	mag_t mag_s2 [N_WHEELS];
	div_t div_st [DIV_STEPS+1];
	div_t last;
	whl_t wv     [N_WHEELS];
	logic rem_ok, pass_ok;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			square_q <= 1'b0;
		end else if (cfg_we) begin
			square_q <= cfg_wdata;
		end
	end

	// Per-stage advance: a stage loads when empty or when its successor moves
	always_comb begin
		adv[N_STAGES-1] = !vld_q[N_STAGES-1] || wheels.ready;
		for (int k = N_STAGES - 2; k >= 0; k--) begin
			adv[k] = !vld_q[k] || adv[k+1];
		end
	end

	assign axes.ready = adv[0];

	// Valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[0]) begin
				vld_q[0] <= axes.valid;
			end
			for (int k = 1; k < N_STAGES; k++) begin
				if (adv[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	// Datapath stages
	hdm_shape u_shape (
		.clk          (clk),
		.en           (adv[0]),
		.square       (square_q),
		.forward_axis (axes.forward_axis),
		.side_axis    (axes.side_axis),
		.rotate_axis  (axes.rotate_axis),
		.off_s1       (off_s1)
	);

	hdm_mix u_mix (
		.clk    (clk),
		.en     (adv[1]),
		.off_s1 (off_s1),
		.e_s2   (e_s2),
		.mag_s2 (mag_s2)
	);

	hdm_limit u_limit (
		.clk    (clk),
		.en     (adv[2]),
		.e_s2   (e_s2),
		.mag_s2 (mag_s2),
		.div_s3 (div_st[0])
	);

	for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
		hdm_div_step u_step (
			.clk    (clk),
			.en     (adv[3+g]),
			.d_in   (div_st[g]),
			.div_sk (div_st[g+1])
		);
	end

	assign last = div_st[DIV_STEPS];

	// Result: signed quotient or raw offset, re-centred on 127
	always_comb begin
		for (int k = 0; k < N_WHEELS; k++) begin
			if (last.scale) begin
				wv[k] = last.neg[k]
					? whl_t'(CENTRE) - whl_t'({3'b000, last.quo[k]})
					: whl_t'(CENTRE) + whl_t'({3'b000, last.quo[k]});
			end else begin
				wv[k] = $signed(last.off[k]) + whl_t'(CENTRE);
			end
		end
	end

	assign wheels.valid           = vld_q[N_STAGES-1];
	assign wheels.front_left_pwm  = wv[0][AXIS_W-1:0];
	assign wheels.front_right_pwm = wv[1][AXIS_W-1:0];
	assign wheels.back_left_pwm   = wv[2][AXIS_W-1:0];
	assign wheels.back_right_pwm  = wv[3][AXIS_W-1:0];

	// Check helpers
	always_comb begin
		rem_ok  = 1'b1;
		pass_ok = 1'b1;
		for (int k = 0; k < N_WHEELS; k++) begin
			if ({1'b0, div_st[0].rem[k]} >= {div_st[0].dsr, 1'b0}) begin
				rem_ok = 1'b0;
			end
			if ($signed(last.off[k]) >= whl_t'(CENTRE)
					|| $signed(last.off[k]) <= -whl_t'(CENTRE)) begin
				pass_ok = 1'b0;
			end
		end
	end

	// A free output must let the whole pipe, and so the input, move
	a_ready_chain: assert property (@(posedge clk) disable iff (!arst_n)
		wheels.ready |-> axes.ready)
		else $error("input stalled while output is ready");

	// Numerator must stay below 128 * limit or the quotient overflows
	a_num_range: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_q[2] && div_st[0].scale) |-> rem_ok)
		else $error("divider numerator out of range");

	// Unscaled wheels must lie strictly inside +/-127
	a_pass_range: assert property (@(posedge clk) disable iff (!arst_n)
		(wheels.valid && !last.scale) |-> pass_ok)
		else $error("pass-through wheel at or beyond limit");

	// A result held under back-pressure stays valid next cycle
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(wheels.valid && !wheels.ready) |=> wheels.valid)
		else $error("stalled result lost");

endmodule

@@ rtl/core/hdm_shape.sv @@
// ----------------------------------------------------------------------------
// hdm_shape - stage 1: axis centring and optional quadratic shaping
// Removes the 127 offset and, when enabled, applies sign(d)*d*d/128.
// ----------------------------------------------------------------------------
module hdm_shape import hdm_pkg::*; (
	input  logic  clk,
	input  logic  en,
	input  logic  square,
	input  axis_t forward_axis,
	input  axis_t side_axis,
	input  axis_t rotate_axis,
	output off_t  off_s1 [N_AXES]
);

	// Signed square, truncated toward zero (shift of the magnitude)
	function automatic off_t shape_off(axis_t v, logic sq);
		off_t       d;
		logic [7:0] m;
		logic [14:0] p;
		off_t       s;
		d = off_t'({1'b0, v}) - off_t'(CENTRE);
		m = d[OFF_W-1] ? 8'(-d) : d[7:0];
		p = 15'(m) * 15'(m);
		s = off_t'({1'b0, p[14:7]});
		return sq ? (d[OFF_W-1] ? -s : s) : d;
	endfunction

	axis_t raw [N_AXES];

	assign raw[0] = forward_axis;
	assign raw[1] = side_axis;
	assign raw[2] = rotate_axis;

	// Stage register
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < N_AXES; i++) begin
				off_s1[i] <= shape_off(raw[i], square);
			end
		end
	end

endmodule

@@ rtl/core/hdm_mix.sv @@
// ----------------------------------------------------------------------------
// hdm_mix - stage 2: wheel mixing and magnitudes
// Combines forward, side and rotate offsets into four wheel offsets; the
// forward axis is inverted for the right-hand wheels.
// ----------------------------------------------------------------------------
module hdm_mix import hdm_pkg::*; (
	input  logic clk,
	input  logic en,
	input  off_t off_s1 [N_AXES],
	output whl_t e_s2   [N_WHEELS],
	output mag_t mag_s2 [N_WHEELS]
);

	whl_t f, s, r;
	whl_t e [N_WHEELS];

	// Mixing matrix
	always_comb begin
		f = whl_t'(off_s1[0]);
		s = whl_t'(off_s1[1]);
		r = whl_t'(off_s1[2]);
		e[0] =  f + s + r;   // front left
		e[1] = -f + s + r;   // front right
		e[2] =  f - s + r;   // back left
		e[3] = -f - s + r;   // back right
	end

	// Stage register with absolute values
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < N_WHEELS; k++) begin
				e_s2[k]   <= e[k];
				mag_s2[k] <= e[k][WHL_W-1] ? mag_t'(-e[k]) : mag_t'(e[k]);
			end
		end
	end

endmodule

@@ rtl/core/hdm_limit.sv @@
// ----------------------------------------------------------------------------
// hdm_limit - stage 3: largest wheel magnitude and divider set-up
// Finds the limit over the four wheels, decides whether to rescale and loads
// the divider lanes with |w|*127 and the aligned limit.
// ----------------------------------------------------------------------------
module hdm_limit import hdm_pkg::*; (
	input  logic clk,
	input  logic en,
	input  whl_t e_s2   [N_WHEELS],
	input  mag_t mag_s2 [N_WHEELS],
	output div_t div_s3
);

	mag_t m01, m23, lim;
	div_t nxt;

	// Max tree and numerator preparation
	always_comb begin
		m01 = (mag_s2[0] > mag_s2[1]) ? mag_s2[0] : mag_s2[1];
		m23 = (mag_s2[2] > mag_s2[3]) ? mag_s2[2] : mag_s2[3];
		lim = (m01 > m23) ? m01 : m23;
		nxt.scale = (lim >= mag_t'(CENTRE));
		nxt.dsr   = NUM_W'(lim) << (QUO_W - 1);
		for (int k = 0; k < N_WHEELS; k++) begin
			// x*127 as x*128 - x
			nxt.rem[k] = (NUM_W'(mag_s2[k]) << 7) - NUM_W'(mag_s2[k]);
			nxt.quo[k] = '0;
			nxt.neg[k] = e_s2[k][WHL_W-1];
			nxt.off[k] = e_s2[k];
		end
	end

	// Stage register
	always_ff @(posedge clk) begin
		if (en) begin
			div_s3 <= nxt;
		end
	end

endmodule

@@ rtl/core/hdm_div_step.sv @@
// ----------------------------------------------------------------------------
// hdm_div_step - one restoring division step for all four wheel lanes
// Compares the remainder with the aligned limit, subtracts when it fits,
// shifts the remainder left and appends one quotient bit.
// ----------------------------------------------------------------------------
module hdm_div_step import hdm_pkg::*; (
	input  logic clk,
	input  logic en,
	input  div_t d_in,
	output div_t div_sk
);

	div_t nxt;
	logic [N_WHEELS-1:0] fits;

	// Compare, subtract, shift
	always_comb begin
		nxt = d_in;
		for (int k = 0; k < N_WHEELS; k++) begin
			fits[k]    = (d_in.rem[k] >= d_in.dsr);
			nxt.rem[k] = NUM_W'((fits[k] ? (d_in.rem[k] - d_in.dsr) : d_in.rem[k]) << 1);
			nxt.quo[k] = {d_in.quo[k][QUO_W-2:0], fits[k]};
		end
	end

	// Stage register
	always_ff @(posedge clk) begin
		if (en) begin
			div_sk <= nxt;
		end
	end

endmodule
